[hw/rtl/scr_pkg.sv]
// shared types and constants of the subpixel circle rasterizer
package scr_pkg;

	localparam int GridWidthDef  = 16;
	localparam int GridHeightDef = 16;
	localparam logic [7:0] StepReset = 8'd64;

	// command modes carried in tuser
	typedef enum logic [1:0] {
		MODE_POINT  = 2'd0,
		MODE_CIRCLE = 2'd1,
		MODE_READ   = 2'd2,
		MODE_NONE   = 2'd3
	} scr_mode_e;

	// controller to datapath
	typedef struct packed {
		logic clr_we;
		logic load;
		logic pt_load;
		logic nbr_rd;
		logic nbr_wr;
		logic pt_next;
		logic upd;
		logic pix_rd;
		logic emit;
	} scr_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic      clr_done;
		scr_mode_e mode;
		logic      single;
		logic      pt_ok;
		logic      nbr_last;
		logic      pt_last;
		logic      loop_go;
	} scr_sts_t;

endpackage

[hw/rtl/subpixel_circle_rasterizer_core.sv]
// Antialiased point and subpixel circle rasterizer with an RGB frame store.
// After reset the frame store is cleared, one pixel per cycle, and no word
// is taken meanwhile. Each command then runs alone through the controller
// and returns one word. A circle runs in walk steps: every step splats eight
// points, and each point on the grid does four read-modify-write passes on
// the single frame store port.
// A finished word waits in the output register while the next command starts.
module subpixel_circle_rasterizer_core import scr_pkg::*; #(
	parameter int GRID_WIDTH  = GridWidthDef,
	parameter int GRID_HEIGHT = GridHeightDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // pos_x[15:0], pos_y[31:16], radius[47:32], color[71:48]
	input  logic [1:0]  s_tuser,  // mode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // pixel_color[23:0]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	scr_cmd_t    cmd;
	scr_sts_t    sts;
	logic [7:0]  step_q;
	logic        out_free;
	logic [23:0] res;
	logic        m_valid_q;
	logic [23:0] m_data_q;

	// configuration register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {24'd0, step_q} : 32'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			step_q <= StepReset;
		else if (psel && penable && pwrite && pready && paddr[2] == 1'b0)
			step_q <= pwdata[7:0];
	end

	// output word register
	assign out_free = !m_valid_q || m_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (cmd.emit)
			m_valid_q <= 1'b1;
		else if (m_tready)
			m_valid_q <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (cmd.emit)
			m_data_q <= res;
	end

	scr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.out_free (out_free),
		.sts      (sts),
		.cmd      (cmd)
	);

	scr_dp #(
		.GRID_WIDTH  (GRID_WIDTH),
		.GRID_HEIGHT (GRID_HEIGHT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_mode     (s_tuser),
		.in_pos_x    (s_tdata[15:0]),
		.in_pos_y    (s_tdata[31:16]),
		.in_radius   (s_tdata[47:32]),
		.in_color    (s_tdata[71:48]),
		.circle_step (step_q),
		.res         (res)
	);

endmodule

[hw/rtl/scr_dp.sv]
// datapath: frame store, circle walk registers, point and neighbor arithmetic
module scr_dp import scr_pkg::*; #(
	parameter int GRID_WIDTH  = GridWidthDef,
	parameter int GRID_HEIGHT = GridHeightDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  scr_cmd_t    cmd,
	output scr_sts_t    sts,
	input  logic [1:0]  in_mode,
	input  logic [15:0] in_pos_x,
	input  logic [15:0] in_pos_y,
	input  logic [15:0] in_radius,
	input  logic [23:0] in_color,
	input  logic [7:0]  circle_step,
	output logic [23:0] res
);

	localparam int NPIX = GRID_WIDTH * GRID_HEIGHT;
	localparam int AW   = $clog2(NPIX);
	localparam int XW   = $clog2(GRID_WIDTH);
	localparam int YW   = $clog2(GRID_HEIGHT);
	localparam logic signed [17:0] LimX = 18'((GRID_WIDTH - 1) * 256);
	localparam logic signed [17:0] LimY = 18'((GRID_HEIGHT - 1) * 256);

	scr_mode_e          mode_q;
	logic signed [15:0] cx_q, cy_q;
	logic [23:0]        col_q;
	logic signed [17:0] a_q, b_q;
	logic signed [20:0] e_q;
	logic [8:0]         stp_q;
	logic               single_q;
	logic [2:0]         p_q;
	logic [1:0]         k_q;
	logic               pt_ok_q;
	logic [XW-1:0]      px_q;
	logic [YW-1:0]      py_q;
	logic [7:0]         xx_q, yy_q, w_q;
	logic               nok_q;
	logic [AW-1:0]      waddr_q, rd_addr_q, clr_q;
	logic               rd_ok_q;
	logic [23:0]        rd_q;
	logic [23:0]        mem [NPIX];

	// load-time decode
	logic [8:0]  stp;
	logic        rad_short;
	logic [7:0]  rpx, rpy;
	logic        rd_ok;
	logic [AW-1:0] rd_addr;
	always_comb begin
		stp   = (circle_step == 8'd0) ? 9'd1 : {1'b0, circle_step};
		rad_short = {1'b0, in_radius} <= {7'd0, stp, 1'b0};
		rpx   = in_pos_x[15:8];
		rpy   = in_pos_y[15:8];
		rd_ok = !rpx[7] && !rpy[7] && (32'(rpx) < 32'(GRID_WIDTH))
			&& (32'(rpy) < 32'(GRID_HEIGHT));
		rd_addr = AW'(32'(rpy) * 32'(GRID_WIDTH) + 32'(rpx));
	end

	// symmetric point of the current step
	logic signed [17:0] u, v, cxe, cye, x, y;
	logic               negx, negy, ok;
	logic [7:0]         fx, fy;
	always_comb begin
		u    = p_q[0] ? b_q : a_q;
		v    = p_q[0] ? a_q : b_q;
		negx = p_q[2] ^ p_q[1];
		negy = p_q[2];
		cxe  = 18'(cx_q);
		cye  = 18'(cy_q);
		x    = negx ? cxe - u : cxe + u;
		y    = negy ? cye - v : cye + v;
		ok   = !x[17] && !y[17] && (x <= LimX) && (y <= LimY);
		fx   = x[7:0];
		fy   = y[7:0];
	end

	// neighbor address and wu weight
	logic [XW:0]   nx;
	logic [YW:0]   ny;
	logic          nok;
	logic [7:0]    wa, wb, w;
	logic [15:0]   wprod;
	logic [AW-1:0] nbr_addr, raddr;
	always_comb begin
		nx       = {1'b0, px_q} + (XW+1)'(k_q[0]);
		ny       = {1'b0, py_q} + (YW+1)'(k_q[1]);
		nok      = (32'(nx) < 32'(GRID_WIDTH)) && (32'(ny) < 32'(GRID_HEIGHT));
		nbr_addr = AW'(32'(ny) * 32'(GRID_WIDTH) + 32'(nx));
		wa       = k_q[0] ? xx_q : ~xx_q;
		wb       = k_q[1] ? yy_q : ~yy_q;
		wprod    = 16'(wa * wb) + 16'(wa) + 16'(wb);
		w        = wprod[15:8];
		raddr    = cmd.pix_rd ? rd_addr_q : nbr_addr;
	end

	// scaled colour, saturating add
	logic [23:0] newpix;
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			logic [15:0] cp;
			logic [8:0]  sm;
			cp = 16'(col_q[c*8 +: 8] * w_q);
			sm = {1'b0, rd_q[c*8 +: 8]} + {1'b0, cp[15:8]};
			newpix[c*8 +: 8] = sm[8] ? 8'hFF : sm[7:0];
		end
	end

	// midpoint step update
	logic signed [17:0] bn, an;
	logic signed [20:0] s21, e_nx;
	always_comb begin
		bn   = b_q + 18'(stp_q);
		an   = a_q - 18'(stp_q);
		s21  = signed'(21'(stp_q));
		if (e_q < 0)
			e_nx = e_q + 21'(bn) + 21'(bn) + s21;
		else
			e_nx = e_q + ((21'(bn) - 21'(an) + s21) <<< 1);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			p_q   <= '0;
			k_q   <= '0;
		end else begin
			if (cmd.clr_we)
				clr_q <= clr_q + AW'(1);
			if (cmd.load)
				p_q <= '0;
			else if (cmd.pt_next)
				p_q <= p_q + 3'd1;
			if (cmd.pt_load)
				k_q <= '0;
			else if (cmd.nbr_wr)
				k_q <= k_q + 2'd1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q    <= scr_mode_e'(in_mode);
			cx_q      <= signed'(in_pos_x);
			cy_q      <= signed'(in_pos_y);
			col_q     <= in_color;
			stp_q     <= stp;
			single_q  <= (in_mode != MODE_CIRCLE) || rad_short;
			a_q       <= ((in_mode != MODE_CIRCLE) || rad_short) ? '0
				: signed'({2'b00, in_radius});
			b_q       <= '0;
			e_q       <= signed'(21'(stp)) - signed'(21'(in_radius));
			rd_ok_q   <= rd_ok;
			rd_addr_q <= rd_addr;
		end
		if (cmd.pt_load) begin
			pt_ok_q <= ok;
			px_q    <= x[XW+7:8];
			py_q    <= y[YW+7:8];
			xx_q    <= (fx == 8'd0) ? 8'd0 : fx - 8'd1;
			yy_q    <= (fy == 8'd0) ? 8'd0 : fy - 8'd1;
		end
		if (cmd.nbr_rd) begin
			w_q     <= w;
			nok_q   <= nok;
			waddr_q <= nbr_addr;
		end
		if (cmd.upd) begin
			b_q <= bn;
			e_q <= e_nx;
			if (e_q >= 0)
				a_q <= an;
		end
	end

	// frame store, read data held until the next requested read
	always_ff @(posedge clk) begin
		if (cmd.clr_we)
			mem[clr_q] <= '0;
		else if (cmd.nbr_wr && nok_q)
			mem[waddr_q] <= newpix;
		if (cmd.nbr_rd || cmd.pix_rd)
			rd_q <= mem[raddr];
	end

	assign res = (mode_q == MODE_READ && rd_ok_q) ? rd_q : 24'd0;

	always_comb begin
		sts.clr_done = (clr_q == AW'(NPIX - 1));
		sts.mode     = mode_q;
		sts.single   = single_q;
		sts.pt_ok    = pt_ok_q;
		sts.nbr_last = (k_q == 2'd3);
		sts.pt_last  = (p_q == 3'd7);
		sts.loop_go  = (a_q >= b_q);
	end

endmodule

[hw/rtl/scr_ctrl.sv]
// controller: sequences clearing, point splats, circle steps and reads
module scr_ctrl import scr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic     out_free,
	input  scr_sts_t sts,
	output scr_cmd_t cmd
);

	typedef enum logic [10:0] {
		ST_CLEAR = 11'b00000000001,
		ST_IDLE  = 11'b00000000010,
		ST_DISP  = 11'b00000000100,
		ST_CHK   = 11'b00000001000,
		ST_PT    = 11'b00000010000,
		ST_NW    = 11'b00000100000,
		ST_NA    = 11'b00001000000,
		ST_NXT   = 11'b00010000000,
		ST_UPD   = 11'b00100000000,
		ST_RD    = 11'b01000000000,
		ST_DONE  = 11'b10000000000
	} state_t;

	state_t state_q, state_d;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_we = 1'b1;
				if (sts.clr_done)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DISP;
				end
			end
			ST_DISP: begin
				unique case (sts.mode)
					MODE_POINT, MODE_CIRCLE: state_d = ST_PT;
					MODE_READ:               state_d = ST_RD;
					default:                 state_d = ST_DONE;
				endcase
			end
			ST_CHK: begin
				state_d = sts.loop_go ? ST_PT : ST_DONE;
			end
			ST_PT: begin
				cmd.pt_load = 1'b1;
				state_d     = ST_NW;
			end
			ST_NW: begin
				if (!sts.pt_ok)
					state_d = ST_NXT;
				else begin
					cmd.nbr_rd = 1'b1;
					state_d    = ST_NA;
				end
			end
			ST_NA: begin
				cmd.nbr_wr = 1'b1;
				state_d    = sts.nbr_last ? ST_NXT : ST_NW;
			end
			ST_NXT: begin
				if (sts.single)
					state_d = ST_DONE;
				else begin
					cmd.pt_next = 1'b1;
					state_d     = sts.pt_last ? ST_UPD : ST_PT;
				end
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = ST_CHK;
			end
			ST_RD: begin
				cmd.pix_rd = 1'b1;
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_d;
	end

`ifndef NO_ASSERTIONS
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> out_free) else $error("word emitted into a full output");
	a_load_disp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_DISP) else $error("load not followed by dispatch");
	a_write_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.nbr_wr |-> $past(cmd.nbr_rd)) else $error("pixel write without read");
`endif

endmodule

[tb/subpixel_circle_rasterizer_core_test.sv]
// self-checking testbench of the subpixel circle rasterizer core
`timescale 1ns / 1ps

module subpixel_circle_rasterizer_core_test;
	import scr_pkg::*;

	localparam int GridW = 16;
	localparam int GridH = 16;
	localparam logic [2:0] AddrCircleStep = 3'd0;

	typedef struct {
		scr_mode_e   mode;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [15:0] radius;
		logic [23:0] color;
	} draw_cmd_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;  // pos_x[15:0], pos_y[31:16], radius[47:32], color[71:48]
	logic [1:0]  s_tuser = '0;  // mode[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;       // pixel_color[23:0]
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// shadow of the frame store and the step register
	logic [23:0] shadow_pixels [GridW*GridH];
	logic [7:0]  shadow_step;

	draw_cmd_t   cmd_q [$];
	logic [23:0] pixel_expect_q [$];
	int          sent_cnt = 0;
	int          taken_cnt = 0;
	int          word_cnt = 0;
	int          err_cnt = 0;
	int          circle_cnt = 0;
	int          read_cnt = 0;
	int          src_idle = 31;
	int          snk_idle = 80;
	int          stall_left = 0;
	bit          stall_done = 1'b0;

	subpixel_circle_rasterizer_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// saturating add of one weighted color into a pixel
	function automatic void blend_pixel(int px, int py, logic [23:0] color, int w);
		int idx;
		int ch;
		int sum;
		logic [23:0] pix;
		if (px < 0 || py < 0 || px >= GridW || py >= GridH) return;
		idx = py * GridW + px;
		pix = shadow_pixels[idx];
		for (ch = 0; ch < 3; ch++) begin
			sum = int'(pix[ch*8 +: 8]) + ((int'(color[ch*8 +: 8]) * w) >> 8);
			pix[ch*8 +: 8] = (sum > 255) ? 8'd255 : sum[7:0];
		end
		shadow_pixels[idx] = pix;
	endfunction

	function automatic int corner_weight(int a, int b);
		return ((a * b + a + b) >> 8) & 255;
	endfunction

	// antialiased point spread over four neighbors
	function automatic void splat_point(int x, int y, logic [23:0] color);
		int px;
		int py;
		int xx;
		int yy;
		if (x < 0 || y < 0 || x > (GridW - 1) * 256 || y > (GridH - 1) * 256) return;
		px = x / 256;
		py = y / 256;
		xx = ((x & 255) * 255) >> 8;
		yy = ((y & 255) * 255) >> 8;
		blend_pixel(px, py, color, corner_weight(255 - xx, 255 - yy));
		blend_pixel(px + 1, py, color, corner_weight(xx, 255 - yy));
		blend_pixel(px, py + 1, color, corner_weight(255 - xx, yy));
		blend_pixel(px + 1, py + 1, color, corner_weight(xx, yy));
	endfunction

	// midpoint circle walk in subpixel steps
	function automatic void walk_circle(int cx, int cy, int rad, logic [23:0] color);
		longint stp;
		longint a;
		longint b;
		longint e;
		int ia;
		int ib;
		stp = (shadow_step == 0) ? 1 : shadow_step;
		if (rad <= 2 * stp) begin
			splat_point(cx, cy, color);
			return;
		end
		a = rad;
		b = 0;
		e = stp - rad;
		while (a >= b) begin
			ia = int'(a);
			ib = int'(b);
			splat_point(cx + ia, cy + ib, color);
			splat_point(cx + ib, cy + ia, color);
			splat_point(cx - ia, cy + ib, color);
			splat_point(cx - ib, cy + ia, color);
			splat_point(cx - ia, cy - ib, color);
			splat_point(cx - ib, cy - ia, color);
			splat_point(cx + ia, cy - ib, color);
			splat_point(cx + ib, cy - ia, color);
			b += stp;
			if (e < 0) begin
				e += 2 * b + stp;
			end else begin
				a -= stp;
				e += 2 * (b - a + stp);
			end
		end
	endfunction

	// apply one command to the shadow store and return the pixel word it yields
	function automatic logic [23:0] draw_and_read(draw_cmd_t c);
		int rx;
		int ry;
		logic [23:0] res;
		res = '0;
		case (c.mode)
			MODE_POINT: begin
				splat_point(int'($signed(c.pos_x)), int'($signed(c.pos_y)), c.color);
			end
			MODE_CIRCLE: begin
				walk_circle(int'($signed(c.pos_x)), int'($signed(c.pos_y)), int'(c.radius),
					c.color);
			end
			MODE_READ: begin
				rx = int'($signed(c.pos_x[15:8]));
				ry = int'($signed(c.pos_y[15:8]));
				if (rx >= 0 && ry >= 0 && rx < GridW && ry < GridH)
					res = shadow_pixels[ry * GridW + rx];
			end
			default: res = '0;
		endcase
		return res;
	endfunction

	// driver: offer the next command word at the falling edge
	always @(negedge clk) begin
		if (s_tvalid && taken_cnt != sent_cnt) begin
			// still waiting for the handshake
		end else if (arst_n && cmd_q.size() != 0 && $urandom_range(99) >= src_idle) begin
			draw_cmd_t c;
			c = cmd_q.pop_front();
			s_tdata <= {c.color, c.radius, c.pos_y, c.pos_x};
			s_tuser <= c.mode;
			s_tvalid <= 1'b1;
			sent_cnt++;
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	// receiver: random back-pressure plus one long hold-off
	always @(negedge clk) begin
		if (!stall_done && taken_cnt >= 600) begin
			stall_done = 1'b1;
			stall_left = 600;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_idle);
		end
	end

	// monitor: check results, then predict accepted commands
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			word_cnt++;
			if (pixel_expect_q.size() == 0) begin
				$error("unexpected result word pixel_color=%06h", m_tdata);
				err_cnt++;
			end else begin
				logic [23:0] want;
				want = pixel_expect_q.pop_front();
				if (m_tdata !== want) begin
					$error("pixel_color mismatch: expected %06h actual %06h", want, m_tdata);
					err_cnt++;
				end
			end
		end
		if (s_tvalid && s_tready) begin
			draw_cmd_t c;
			c.pos_x = s_tdata[15:0];
			c.pos_y = s_tdata[31:16];
			c.radius = s_tdata[47:32];
			c.color = s_tdata[71:48];
			c.mode = scr_mode_e'(s_tuser);
			if (c.mode == MODE_CIRCLE) circle_cnt++;
			if (c.mode == MODE_READ) read_cnt++;
			pixel_expect_q.push_back(draw_and_read(c));
			taken_cnt++;
		end
	end

	task automatic push_cmd(scr_mode_e mode, int x, int y, int rad, logic [23:0] color);
		draw_cmd_t c;
		c.mode = mode;
		c.pos_x = x[15:0];
		c.pos_y = y[15:0];
		c.radius = rad[15:0];
		c.color = color;
		cmd_q.push_back(c);
	endtask

	// random command, mostly aimed at the grid, radius up to max_rad
	task automatic push_random(int count, int max_rad);
		int i;
		int sel;
		int x;
		int y;
		scr_mode_e mode;
		for (i = 0; i < count; i++) begin
			sel = $urandom_range(99);
			mode = (sel < 35) ? MODE_POINT : (sel < 65) ? MODE_CIRCLE :
				(sel < 95) ? MODE_READ : MODE_NONE;
			if ($urandom_range(9) == 0) begin
				x = $urandom_range(65535);
				y = $urandom_range(65535);
			end else begin
				x = $urandom_range(GridW * 256 + 255) - 256;
				y = $urandom_range(GridH * 256 + 255) - 256;
			end
			push_cmd(mode, x, y, $urandom_range(max_rad), 24'($urandom_range(24'hffffff)));
		end
	endtask

	// wait until every command is taken and every result has come back
	task automatic drain;
		while (cmd_q.size() != 0 || taken_cnt != sent_cnt || s_tvalid ||
				pixel_expect_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_step(logic [7:0] value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= AddrCircleStep;
		pwdata <= {24'd0, value};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		shadow_step = value;
	endtask

	function automatic int rad_cap(int mult);
		int s;
		s = (shadow_step == 0) ? 1 : shadow_step;
		return (s * mult > 65535) ? 65535 : s * mult;
	endfunction

	// stimulus
	initial begin
		logic [7:0] rnd_step;
		foreach (shadow_pixels[i]) shadow_pixels[i] = '0;
		shadow_step = StepReset;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: edges, saturation, every mode, small radius, reads outside
		push_cmd(MODE_POINT, 0, 0, 0, 24'hffffff);
		push_cmd(MODE_POINT, 0, 0, 0, 24'hffffff);
		push_cmd(MODE_READ, 0, 0, 0, 24'h0);
		push_cmd(MODE_POINT, 15 * 256, 15 * 256, 0, 24'h123456);
		push_cmd(MODE_POINT, 15 * 256 + 1, 3 * 256, 0, 24'hffffff);
		push_cmd(MODE_POINT, -1, 4 * 256, 0, 24'hffffff);
		push_cmd(MODE_POINT, 14 * 256 + 255, 14 * 256 + 255, 0, 24'hff8001);
		push_cmd(MODE_READ, 15 * 256, 15 * 256 + 200, 0, 24'h0);
		push_cmd(MODE_POINT, 5 * 256 + 128, 6 * 256 + 64, 0, 24'h80ff7f);
		push_cmd(MODE_READ, 5 * 256, 6 * 256, 0, 24'h0);
		push_cmd(MODE_CIRCLE, 8 * 256, 8 * 256, 128, 24'h00ff00);
		push_cmd(MODE_CIRCLE, 8 * 256, 8 * 256, 129, 24'h0000ff);
		push_cmd(MODE_CIRCLE, 8 * 256 + 77, 7 * 256 + 3, 6 * 256 + 50, 24'hff0000);
		push_cmd(MODE_CIRCLE, 0, 0, 0, 24'hffffff);
		push_cmd(MODE_CIRCLE, 32767, -32768, 300, 24'hffffff);
		push_cmd(MODE_READ, 8 * 256, 2 * 256, 0, 24'h0);
		push_cmd(MODE_READ, -256, 0, 0, 24'h0);
		push_cmd(MODE_READ, 0, 16 * 256, 0, 24'h0);
		push_cmd(MODE_READ, 32767, 32767, 0, 24'h0);
		push_cmd(MODE_READ, -32768, -32768, 0, 24'h0);
		push_cmd(MODE_NONE, 3 * 256, 3 * 256, 1000, 24'hffffff);
		push_cmd(MODE_READ, 3 * 256, 3 * 256, 0, 24'h0);
		push_random(200, rad_cap(12));
		drain();

		// tiny step, small radii only
		write_step(8'd1);
		push_random(250, 40);
		drain();

		// widest step, a few full-range radii
		src_idle = 80;
		snk_idle = 31;
		write_step(8'd255);
		push_cmd(MODE_CIRCLE, 8 * 256, 8 * 256, 65535, 24'hffffff);
		push_cmd(MODE_CIRCLE, -32768, 32767, 65535, 24'h010203);
		push_cmd(MODE_CIRCLE, 4 * 256, 12 * 256, 511, 24'h404040);
		push_cmd(MODE_CIRCLE, 4 * 256, 12 * 256, 510, 24'h404040);
		push_random(350, rad_cap(14));
		drain();

		rnd_step = 8'($urandom_range(2, 255));
		write_step(rnd_step);
		push_random(350, rad_cap(14));
		drain();

		// no idling on either side
		src_idle = 0;
		snk_idle = 0;
		write_step(8'd2);
		push_random(350, rad_cap(16));
		drain();

		// zero step acts as one
		write_step(8'd0);
		push_random(100, 30);
		drain();

		rnd_step = 8'($urandom_range(1, 255));
		write_step(rnd_step);
		push_random(350, rad_cap(14));
		drain();

		repeat (50) @(posedge clk);
		$display("covered %0d commands (%0d circles, %0d reads), %0d result words checked",
			taken_cnt, circle_cnt, read_cnt, word_cnt);
		$display("step settings 64, 1, 255, 2, 0 and random; long output stall applied");
		if (err_cnt == 0 && pixel_expect_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// overall limit
	initial begin
		#50_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
